// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the heap allocator.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/bfha_pkg.sv =====
// Types, codes and defaults of the best-fit heap allocator.
// No dependencies; used by every module of the block but bfha_ram.
package bfha_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int HEAP_BYTES_DEF   = 65536;

  localparam logic [16:0] LIMIT_RESET = 17'd65536;

  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_RESIZE = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NULL    = 3'd1;
  localparam logic [2:0] ST_OOM     = 3'd2;
  localparam logic [2:0] ST_NOTHEAP = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] request_size;
    logic [15:0] user_address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_address;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] size;
    logic        free;
  } entry_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_PICK_BEST,
    OP_PICK_HIT,
    OP_SHIFT_INIT,
    OP_SHIFT,
    OP_SPLIT_LO,
    OP_SPLIT_HI,
    OP_MARK,
    OP_APPEND,
    OP_SAVE_OLD,
    OP_PASS_INIT,
    OP_PASS,
    OP_PASS_END,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] st;
    logic       zero;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       req_zero;
    logic       addr_zero;
    logic       scan_done;
    logic       best_found;
    logic       hit_found;
    logic       fits_hit;
    logic       split_ok;
    logic       shift_done;
    logic       pass_done;
    logic       oom;
    logic       full;
  } dp_stat_t;

endpackage

// ===== rtl/bfha_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bfha_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bfha_dp.sv =====
// Datapath of the heap allocator: block table RAM, scan, shift and merge passes.
// Depends on bfha_pkg and bfha_ram; driven by commands from bfha_ctrl.
module bfha_dp #(
  parameter int MAX_BLOCKS   = bfha_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = bfha_pkg::HEADER_BYTES_DEF,
  parameter int HEAP_BYTES   = bfha_pkg::HEAP_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bfha_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_wdata,
  input  bfha_pkg::dp_cmd_t   cmd,
  output bfha_pkg::dp_stat_t  stat,
  output bfha_pkg::out_item_t out_data
);

  import bfha_pkg::*;

  localparam int AW    = $clog2(MAX_BLOCKS);
  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int CAP_I = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
  localparam logic [16:0]   CAP     = 17'(CAP_I);
  localparam logic [15:0]   HDR16   = 16'(HEADER_BYTES);
  localparam logic [16:0]   HDR17   = 17'(HEADER_BYTES);
  localparam logic [17:0]   HDR18   = 18'(HEADER_BYTES);
  localparam logic [18:0]   HDR19   = 19'(HEADER_BYTES);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

  // Registers
  in_item_t        item_r,       item_nxt;
  logic [16:0]     need_r,       need_nxt;
  logic [CW-1:0]   count_r,      count_nxt;
  logic [16:0]     top_r,        top_nxt;
  logic [16:0]     limit_r,      limit_nxt;
  logic [CW-1:0]   rp_r,         rp_nxt;
  logic            dv_r,         dv_nxt;
  logic [AW-1:0]   d_idx_r,      d_idx_nxt;
  logic            best_found_r, best_found_nxt;
  logic [AW-1:0]   best_idx_r,   best_idx_nxt;
  logic [15:0]     best_start_r, best_start_nxt;
  logic [15:0]     best_size_r,  best_size_nxt;
  logic            hit_found_r,  hit_found_nxt;
  logic [AW-1:0]   hit_idx_r,    hit_idx_nxt;
  logic [15:0]     hit_start_r,  hit_start_nxt;
  logic [15:0]     hit_size_r,   hit_size_nxt;
  logic            hit_free_r,   hit_free_nxt;
  logic [AW-1:0]   wk_idx_r,     wk_idx_nxt;
  logic [15:0]     wk_start_r,   wk_start_nxt;
  logic [15:0]     wk_size_r,    wk_size_nxt;
  logic            wk_free_r,    wk_free_nxt;
  logic [15:0]     rel_start_r,  rel_start_nxt;
  logic [15:0]     res_r,        res_nxt;
  logic [CW-1:0]   w_r,          w_nxt;
  logic            pend_v_r,     pend_v_nxt;
  entry_t          pend_r,       pend_nxt;
  out_item_t       out_r,        out_nxt;

  // RAM port signals
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  entry_t              ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;

  entry_t        rd_e;
  entry_t        pass_e;
  logic [17:0]   u_lo;
  logic [17:0]   u_hi;
  logic [17:0]   addr18;
  logic [CW-1:0] rp_dec;
  logic [CW-1:0] shift_stop;
  logic [16:0]   lim;

  bfha_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Decode the entry read back and its payload range
  always_comb begin
    rd_e        = entry_t'(ram_rdata);
    pass_e      = rd_e;
    pass_e.free = rd_e.free | (rd_e.start == rel_start_r);
    u_lo        = {2'b00, rd_e.start} + HDR18;
    u_hi        = u_lo + {2'b00, rd_e.size};
    addr18      = {2'b00, item_r.user_address};
    rp_dec      = rp_r - CW'(1);
    shift_stop  = CW'(wk_idx_r) + CW'(1);
    lim         = (limit_r < CAP) ? limit_r : CAP;
  end

  // Status back to the controller
  always_comb begin
    stat.mode       = item_r.mode;
    stat.req_zero   = (item_r.request_size == 16'd0);
    stat.addr_zero  = (item_r.user_address == 16'd0);
    stat.scan_done  = (rp_r == count_r) && !dv_r;
    stat.pass_done  = (rp_r == count_r) && !dv_r;
    stat.shift_done = !(rp_r > shift_stop) && !dv_r;
    stat.best_found = best_found_r;
    stat.hit_found  = hit_found_r;
    stat.fits_hit   = (need_r <= {1'b0, hit_size_r});
    stat.split_ok   = ({2'b00, wk_size_r} >= ({1'b0, need_r} + HDR18 + 18'd4)) &&
                      (count_r < CNT_MAX);
    stat.oom        = ({2'b00, top_r} + HDR19 + {2'b00, need_r}) > {2'b00, lim};
    stat.full       = (count_r >= CNT_MAX);
  end

  // Next state of the datapath per command
  always_comb begin
    item_nxt       = item_r;
    need_nxt       = need_r;
    count_nxt      = count_r;
    top_nxt        = top_r;
    limit_nxt      = limit_r;
    rp_nxt         = rp_r;
    dv_nxt         = 1'b0;
    d_idx_nxt      = d_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_start_nxt = best_start_r;
    best_size_nxt  = best_size_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_start_nxt  = hit_start_r;
    hit_size_nxt   = hit_size_r;
    hit_free_nxt   = hit_free_r;
    wk_idx_nxt     = wk_idx_r;
    wk_start_nxt   = wk_start_r;
    wk_size_nxt    = wk_size_r;
    wk_free_nxt    = wk_free_r;
    rel_start_nxt  = rel_start_r;
    res_nxt        = res_r;
    w_nxt          = w_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_waddr      = wk_idx_r;
    ram_wdata      = pend_r;
    ram_raddr      = rp_r[AW-1:0];

    if (cfg_we) begin
      limit_nxt = cfg_wdata;
    end

    case (cmd.op)
      OP_LOAD: begin
        item_nxt = in_data;
        need_nxt = ({1'b0, in_data.request_size} + 17'd3) & ~17'd3;
      end
      OP_SCAN_INIT: begin
        rp_nxt         = '0;
        best_found_nxt = 1'b0;
        hit_found_nxt  = 1'b0;
      end
      OP_SCAN: begin
        // Issue the next read
        if (rp_r < count_r) begin
          dv_nxt    = 1'b1;
          d_idx_nxt = rp_r[AW-1:0];
          rp_nxt    = rp_r + CW'(1);
        end
        // Track the smallest fitting free block and the first containing block
        if (dv_r) begin
          if (rd_e.free && ({1'b0, rd_e.size} >= need_r) &&
              (!best_found_r || (rd_e.size < best_size_r))) begin
            best_found_nxt = 1'b1;
            best_idx_nxt   = d_idx_r;
            best_start_nxt = rd_e.start;
            best_size_nxt  = rd_e.size;
          end
          if (!hit_found_r && (addr18 >= u_lo) && (addr18 < u_hi)) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = d_idx_r;
            hit_start_nxt = rd_e.start;
            hit_size_nxt  = rd_e.size;
            hit_free_nxt  = rd_e.free;
          end
        end
      end
      OP_PICK_BEST: begin
        wk_idx_nxt   = best_idx_r;
        wk_start_nxt = best_start_r;
        wk_size_nxt  = best_size_r;
        wk_free_nxt  = 1'b0;
        res_nxt      = best_start_r + HDR16;
      end
      OP_PICK_HIT: begin
        wk_idx_nxt   = hit_idx_r;
        wk_start_nxt = hit_start_r;
        wk_size_nxt  = hit_size_r;
        wk_free_nxt  = hit_free_r;
        res_nxt      = hit_start_r + HDR16;
      end
      OP_SHIFT_INIT: begin
        rp_nxt = count_r;
      end
      OP_SHIFT: begin
        // Move entries up by one, top down, to open a slot after the picked block
        if (rp_r > shift_stop) begin
          ram_raddr = rp_dec[AW-1:0];
          dv_nxt    = 1'b1;
          d_idx_nxt = rp_r[AW-1:0];
          rp_nxt    = rp_dec;
        end
        if (dv_r) begin
          ram_we    = 1'b1;
          ram_waddr = d_idx_r;
          ram_wdata = rd_e;
        end
      end
      OP_SPLIT_LO: begin
        ram_we          = 1'b1;
        ram_waddr       = wk_idx_r + AW'(1);
        ram_wdata.start = wk_start_r + HDR16 + need_r[15:0];
        ram_wdata.size  = wk_size_r - need_r[15:0] - HDR16;
        ram_wdata.free  = 1'b1;
      end
      OP_SPLIT_HI: begin
        ram_we          = 1'b1;
        ram_waddr       = wk_idx_r;
        ram_wdata.start = wk_start_r;
        ram_wdata.size  = need_r[15:0];
        ram_wdata.free  = wk_free_r;
        count_nxt       = count_r + CW'(1);
      end
      OP_MARK: begin
        ram_we          = 1'b1;
        ram_waddr       = wk_idx_r;
        ram_wdata.start = wk_start_r;
        ram_wdata.size  = wk_size_r;
        ram_wdata.free  = wk_free_r;
      end
      OP_APPEND: begin
        ram_we          = 1'b1;
        ram_waddr       = count_r[AW-1:0];
        ram_wdata.start = top_r[15:0];
        ram_wdata.size  = need_r[15:0];
        ram_wdata.free  = 1'b0;
        res_nxt         = top_r[15:0] + HDR16;
        count_nxt       = count_r + CW'(1);
        top_nxt         = top_r + HDR17 + need_r;
      end
      OP_SAVE_OLD: begin
        rel_start_nxt = hit_start_r;
      end
      OP_PASS_INIT: begin
        rp_nxt     = '0;
        w_nxt      = '0;
        pend_v_nxt = 1'b0;
      end
      OP_PASS: begin
        if (rp_r < count_r) begin
          dv_nxt    = 1'b1;
          d_idx_nxt = rp_r[AW-1:0];
          rp_nxt    = rp_r + CW'(1);
        end
        // Free the released block, merge free runs, compact in place
        if (dv_r) begin
          if (!pend_v_r) begin
            pend_v_nxt = 1'b1;
            pend_nxt   = pass_e;
          end else if (pend_r.free && pass_e.free) begin
            pend_nxt.size = pend_r.size + HDR16 + pass_e.size;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = w_r[AW-1:0];
            ram_wdata = pend_r;
            w_nxt     = w_r + CW'(1);
            pend_nxt  = pass_e;
          end
        end
      end
      OP_PASS_END: begin
        // Trim a free last block, otherwise flush it
        if (pend_r.free) begin
          top_nxt   = {1'b0, pend_r.start};
          count_nxt = w_r;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = w_r[AW-1:0];
          ram_wdata = pend_r;
          count_nxt = w_r + CW'(1);
        end
      end
      OP_RESULT: begin
        out_nxt.result_address = cmd.zero ? 16'd0 : res_r;
        out_nxt.status         = cmd.st;
      end
      default: begin
      end
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      top_r        <= '0;
      limit_r      <= LIMIT_RESET;
      dv_r         <= 1'b0;
      best_found_r <= 1'b0;
      hit_found_r  <= 1'b0;
      pend_v_r     <= 1'b0;
      rp_r         <= '0;
      w_r          <= '0;
    end else begin
      count_r      <= count_nxt;
      top_r        <= top_nxt;
      limit_r      <= limit_nxt;
      dv_r         <= dv_nxt;
      best_found_r <= best_found_nxt;
      hit_found_r  <= hit_found_nxt;
      pend_v_r     <= pend_v_nxt;
      rp_r         <= rp_nxt;
      w_r          <= w_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    need_r       <= need_nxt;
    d_idx_r      <= d_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_start_r <= best_start_nxt;
    best_size_r  <= best_size_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_start_r  <= hit_start_nxt;
    hit_size_r   <= hit_size_nxt;
    hit_free_r   <= hit_free_nxt;
    wk_idx_r     <= wk_idx_nxt;
    wk_start_r   <= wk_start_nxt;
    wk_size_r    <= wk_size_nxt;
    wk_free_r    <= wk_free_nxt;
    rel_start_r  <= rel_start_nxt;
    res_r        <= res_nxt;
    pend_r       <= pend_nxt;
    out_r        <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// ===== rtl/bfha_ctrl.sv =====
// Controller of the heap allocator: sequences scans, splits, merge passes, result.
// Depends on bfha_pkg; commands bfha_dp and reads its status.
module bfha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bfha_pkg::dp_cmd_t  cmd,
  input  bfha_pkg::dp_stat_t stat
);

  import bfha_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_DECODE    = 13'b0000000000010,
    S_ASCAN     = 13'b0000000000100,
    S_FSCAN     = 13'b0000000001000,
    S_AFTER_F   = 13'b0000000010000,
    S_SPLIT     = 13'b0000000100000,
    S_SHIFT     = 13'b0000001000000,
    S_SPLIT_LO  = 13'b0000010000000,
    S_SPLIT_HI  = 13'b0000100000000,
    S_PASS_INIT = 13'b0001000000000,
    S_PASS      = 13'b0010000000000,
    S_PASS_END  = 13'b0100000000000,
    S_OUT       = 13'b1000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic       grow_r, grow_nxt;
  logic [2:0] st_r, st_nxt;
  logic       zero_r, zero_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Sequence one item
  always_comb begin
    state_nxt = state_r;
    grow_nxt  = grow_r;
    st_nxt    = st_r;
    zero_nxt  = zero_r;
    cmd.op    = OP_NONE;
    cmd.st    = st_r;
    cmd.zero  = zero_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.op   = OP_SCAN_INIT;
        grow_nxt = 1'b0;
        st_nxt   = ST_OK;
        zero_nxt = 1'b0;
        if (stat.mode == MODE_ALLOC || (stat.mode == MODE_RESIZE && stat.addr_zero)) begin
          if (stat.req_zero) begin
            st_nxt    = ST_NULL;
            zero_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_ASCAN;
          end
        end else if (stat.mode inside {MODE_FREE, MODE_RESIZE}) begin
          if (stat.addr_zero) begin
            st_nxt    = ST_NULL;
            zero_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_FSCAN;
          end
        end else begin
          zero_nxt  = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_ASCAN: begin
        cmd.op = OP_SCAN;
        if (stat.scan_done) begin
          if (stat.best_found) begin
            cmd.op    = OP_PICK_BEST;
            state_nxt = S_SPLIT;
          end else if (stat.oom) begin
            st_nxt    = ST_OOM;
            zero_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else if (stat.full) begin
            st_nxt    = ST_FULL;
            zero_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            cmd.op    = OP_APPEND;
            state_nxt = grow_r ? S_PASS_INIT : S_OUT;
          end
        end
      end
      S_FSCAN: begin
        cmd.op = OP_SCAN;
        if (stat.scan_done) begin
          if (!stat.hit_found) begin
            st_nxt    = ST_NOTHEAP;
            zero_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            cmd.op = OP_SAVE_OLD;
            if (stat.mode == MODE_FREE || stat.req_zero) begin
              zero_nxt  = 1'b1;
              state_nxt = S_PASS_INIT;
            end else begin
              state_nxt = S_AFTER_F;
            end
          end
        end
      end
      S_AFTER_F: begin
        // Shrink in place, or allocate anew and release the old block
        if (stat.fits_hit) begin
          cmd.op    = OP_PICK_HIT;
          state_nxt = S_SPLIT;
        end else begin
          cmd.op    = OP_SCAN_INIT;
          grow_nxt  = 1'b1;
          state_nxt = S_ASCAN;
        end
      end
      S_SPLIT: begin
        if (stat.split_ok) begin
          cmd.op    = OP_SHIFT_INIT;
          state_nxt = S_SHIFT;
        end else begin
          cmd.op    = OP_MARK;
          state_nxt = grow_r ? S_PASS_INIT : S_OUT;
        end
      end
      S_SHIFT: begin
        cmd.op = OP_SHIFT;
        if (stat.shift_done) begin
          state_nxt = S_SPLIT_LO;
        end
      end
      S_SPLIT_LO: begin
        cmd.op    = OP_SPLIT_LO;
        state_nxt = S_SPLIT_HI;
      end
      S_SPLIT_HI: begin
        cmd.op    = OP_SPLIT_HI;
        state_nxt = grow_r ? S_PASS_INIT : S_OUT;
      end
      S_PASS_INIT: begin
        cmd.op    = OP_PASS_INIT;
        state_nxt = S_PASS;
      end
      S_PASS: begin
        cmd.op = OP_PASS;
        if (stat.pass_done) begin
          state_nxt = S_PASS_END;
        end
      end
      S_PASS_END: begin
        cmd.op    = OP_PASS_END;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.op    = OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on a new result, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.op == OP_RESULT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      grow_r      <= 1'b0;
      st_r        <= ST_OK;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      grow_r      <= grow_nxt;
      st_r        <= st_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/best_fit_heap_allocator.sv =====
// Top level of the best-fit heap allocator: controller, datapath, assertions.
// Depends on bfha_pkg, bfha_ctrl, bfha_dp (with bfha_ram) and assert_macros.svh.
//
//   channel  ports                          moves
//   input    in_valid / in_ready / in_data  one request item (mode, size, address)
//   result   out_valid / out_ready / out_data  one result item (address, status)
//   config   cfg_we / cfg_wdata             heap_limit, written at once
//
// One item at a time. A null or zero-size request takes the shortest path, and a
// resize that grows into a split hole and then merges the longest; each scan,
// shift and merge pass walks the table through the single read port of the block
// table RAM, one entry per cycle.
// Synchronous reset empties the table at once (count and heap top cleared).
// A result waiting at the output holds the next item in its result state, and
// with it the input, until the waiting result is taken.
`include "assert_macros.svh"

module best_fit_heap_allocator #(
  parameter int MAX_BLOCKS   = bfha_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = bfha_pkg::HEADER_BYTES_DEF,
  parameter int HEAP_BYTES   = bfha_pkg::HEAP_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bfha_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bfha_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_wdata
);

  import bfha_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bfha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  bfha_dp #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES),
    .HEAP_BYTES  (HEAP_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // One item in flight: busy right after an accept
  `ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  // Never overwrite a result that has not been taken
  `ASSERT_IMPL(a_no_overwrite, cmd.op == OP_RESULT, !out_valid || out_ready)
  // A failed request returns no address
  `ASSERT_IMPL(a_err_no_addr, out_valid && out_data.status != ST_OK, out_data.result_address == 16'd0)

endmodule

// ===== tb/best_fit_heap_allocator_chk.sv =====
// Result checker for the best-fit heap allocator: watches the request, result and
// limit ports, tracks its own copy of the block table and compares every result.
// Depends on bfha_pkg for the item types, modes and status codes.
`timescale 1ns / 1ps

module best_fit_heap_allocator_chk (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bfha_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bfha_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_wdata,
  output int                  errors,
  output int                  pending
);

  import bfha_pkg::*;

  localparam int NBLK = MAX_BLOCKS_DEF;
  localparam int HDR  = HEADER_BYTES_DEF;

  // Shadow block table, heap top and growth limit
  int        blk_start [NBLK];
  int        blk_size  [NBLK];
  bit        blk_free  [NBLK];
  int        blk_count;
  int        brk;
  int        grow_limit;
  out_item_t expected_results[$];

  function automatic int usable_limit();
    int lim;
    lim = grow_limit;
    if (lim > HEAP_BYTES_DEF) lim = HEAP_BYTES_DEF;
    if (lim > 65536) lim = 65536;
    return lim;
  endfunction

  function automatic void drop_entry(int i);
    for (int j = i; j + 1 < blk_count; j++) begin
      blk_start[j] = blk_start[j+1];
      blk_size[j]  = blk_size[j+1];
      blk_free[j]  = blk_free[j+1];
    end
    blk_count--;
  endfunction

  // Carve the spare tail off block i as a new free block when it is big enough
  function automatic void carve(int i, int need);
    if (blk_size[i] < need + HDR + 4 || blk_count >= NBLK) return;
    for (int j = blk_count; j > i + 1; j--) begin
      blk_start[j] = blk_start[j-1];
      blk_size[j]  = blk_size[j-1];
      blk_free[j]  = blk_free[j-1];
    end
    blk_start[i+1] = blk_start[i] + HDR + need;
    blk_size[i+1]  = blk_size[i] - need - HDR;
    blk_free[i+1]  = 1'b1;
    blk_size[i]    = need;
    blk_count++;
  endfunction

  function automatic int owner_of(int a);
    for (int i = 0; i < blk_count; i++) begin
      if (a >= blk_start[i] + HDR && a < blk_start[i] + HDR + blk_size[i]) return i;
    end
    return -1;
  endfunction

  // Mark free, coalesce free neighbors, give a free last block back to the top
  function automatic void give_back(int i);
    int k;
    k = 0;
    blk_free[i] = 1'b1;
    while (k + 1 < blk_count) begin
      if (blk_free[k] && blk_free[k+1]) begin
        blk_size[k] += HDR + blk_size[k+1];
        drop_entry(k + 1);
      end else begin
        k++;
      end
    end
    if (blk_count > 0 && blk_free[blk_count-1]) begin
      brk = blk_start[blk_count-1];
      blk_count--;
    end
  endfunction

  function automatic void take(int req, output int addr, output logic [2:0] stat);
    int need;
    int best;
    best = -1;
    addr = 0;
    if (req == 0) begin
      stat = ST_NULL;
      return;
    end
    need = (req + 3) & ~3;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] >= need &&
          (best < 0 || blk_size[i] < blk_size[best])) best = i;
    end
    if (best >= 0) begin
      blk_free[best] = 1'b0;
      carve(best, need);
      stat = ST_OK;
      addr = blk_start[best] + HDR;
      return;
    end
    if (brk + HDR + need > usable_limit()) begin
      stat = ST_OOM;
      return;
    end
    if (blk_count >= NBLK) begin
      stat = ST_FULL;
      return;
    end
    blk_start[blk_count] = brk;
    blk_size[blk_count]  = need;
    blk_free[blk_count]  = 1'b0;
    blk_count++;
    addr = brk + HDR;
    brk  = brk + HDR + need;
    stat = ST_OK;
  endfunction

  function automatic logic [2:0] release_ptr(int a);
    int k;
    if (a == 0) return ST_NULL;
    k = owner_of(a);
    if (k < 0) return ST_NOTHEAP;
    give_back(k);
    return ST_OK;
  endfunction

  function automatic void regrow(int a, int req, output int addr, output logic [2:0] stat);
    int k;
    int need;
    int old_start;
    addr = 0;
    if (a == 0) begin
      take(req, addr, stat);
      return;
    end
    if (req == 0) begin
      stat = release_ptr(a);
      return;
    end
    k = owner_of(a);
    if (k < 0) begin
      stat = ST_NOTHEAP;
      return;
    end
    need = (req + 3) & ~3;
    if (need <= blk_size[k]) begin
      carve(k, need);
      stat = ST_OK;
      addr = blk_start[k] + HDR;
      return;
    end
    old_start = blk_start[k];
    take(need, addr, stat);
    if (stat != ST_OK) begin
      addr = 0;
      return;
    end
    for (int i = 0; i < blk_count; i++) begin
      if (blk_start[i] == old_start) begin
        give_back(i);
        break;
      end
    end
  endfunction

  function automatic out_item_t predict(in_item_t it);
    out_item_t  r;
    int         addr;
    logic [2:0] stat;
    addr = 0;
    stat = ST_OK;
    case (it.mode)
      MODE_ALLOC:  take(int'(it.request_size), addr, stat);
      MODE_FREE:   stat = release_ptr(int'(it.user_address));
      MODE_RESIZE: regrow(int'(it.user_address), int'(it.request_size), addr, stat);
      default: ;
    endcase
    r.result_address = addr[15:0];
    r.status         = stat;
    return r;
  endfunction

  assign pending = expected_results.size();

  // Check results first, then predict the request accepted at the same edge
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      blk_count  = 0;
      brk        = 0;
      grow_limit = int'(LIMIT_RESET);
      errors     = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result addr=%0d status=%0d", $time,
                   out_data.result_address, out_data.status);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data.result_address !== exp_r.result_address) begin
            $display("%0t: result_address expected %0d actual %0d", $time,
                     exp_r.result_address, out_data.result_address);
            errors++;
          end
          if (out_data.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_r.status, out_data.status);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict(in_data));
      if (cfg_we) grow_limit = int'(cfg_wdata);
    end
  end

endmodule

// ===== tb/best_fit_heap_allocator_tb.sv =====
// Stimulus and verdict for the best-fit heap allocator: directed cases, then random
// malloc/free/realloc traffic under several heap limits, with random stalls.
// Depends on bfha_pkg, best_fit_heap_allocator and best_fit_heap_allocator_chk.
`timescale 1ns / 1ps

module best_fit_heap_allocator_tb;
  import bfha_pkg::*;

  localparam int RAND_ITEMS = 900;
  localparam int SETTLE     = 260;

  // Mode code outside the defined operations
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [16:0] cfg_wdata;
  int          errors;
  int          pending;

  bit          calm;
  int          stall_left;
  int          sent;
  int          live_ptrs[$];

  best_fit_heap_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  best_fit_heap_allocator_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: random stall bursts, none near the end
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      out_ready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Collect returned pointers to feed well-formed free and realloc items
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && out_data.result_address != 0) begin
      live_ptrs.push_back(int'(out_data.result_address));
      if (live_ptrs.size() > 48) void'(live_ptrs.pop_front());
    end
  end

  task automatic send(logic [1:0] mode, int req, int addr);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_data.mode         <= mode;
    in_data.request_size <= req[15:0];
    in_data.user_address <= addr[15:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Hold until every result is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_limit(int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v[16:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_ptr();
    if (live_ptrs.size() == 0) return $urandom_range(1, 2000);
    return live_ptrs[$urandom_range(0, live_ptrs.size() - 1)] + 4 * $urandom_range(0, 2);
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom_range(0, 65535);
      2, 3:    return $urandom_range(300, 4000);
      default: return $urandom_range(1, 160);
    endcase
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      send(MODE_ALLOC, pick_size(), 0);
    else if (r < 72) send(MODE_FREE, 0, (r < 70) ? pick_ptr() : $urandom_range(0, 65535));
    else if (r < 94) send(MODE_RESIZE, pick_size(), (r < 91) ? pick_ptr() : 0);
    else if (r < 97) send(MODE_FREE, 0, $urandom_range(0, 65535));
    else             send(MODE_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  task automatic release_all();
    foreach (live_ptrs[i]) send(MODE_FREE, 0, live_ptrs[i]);
  endtask

  initial begin
    int limits[6];
    limits = '{65536, 0, 65535, 3000, 131071, 65536};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    calm      = 1'b0;
    sent      = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: null and zero sizes, rounding, holes, free twice, realloc forms
    send(MODE_ALLOC, 0, 0);
    send(MODE_ALLOC, 1, 0);
    send(MODE_ALLOC, 100, 0);
    send(MODE_ALLOC, 8, 0);
    send(MODE_FREE, 0, 36);
    send(MODE_FREE, 0, 40);
    send(MODE_ALLOC, 20, 0);
    send(MODE_RESIZE, 4, 44);
    send(MODE_RESIZE, 200, 16);
    send(MODE_RESIZE, 12, 0);
    send(MODE_RESIZE, 0, 152);
    send(MODE_RESIZE, 8, 65000);
    send(MODE_FREE, 0, 0);
    send(MODE_FREE, 0, 1);
    send(MODE_FREE, 0, 65535);
    send(MODE_UNUSED, 65535, 65535);
    send(MODE_ALLOC, 65535, 0);
    send(MODE_RESIZE, 65535, 36);
    send(MODE_RESIZE, 0, 0);
    send(MODE_RESIZE, 0, 3);

    // Fill the block table, then reuse a large hole while it is full
    drain();
    release_all();
    for (int i = 0; i < 72; i++) send(MODE_ALLOC, (i % 4 == 0) ? 100 : 4, 0);
    drain();
    send(MODE_FREE, 0, live_ptrs[live_ptrs.size() - 40]);
    send(MODE_FREE, 0, live_ptrs[live_ptrs.size() - 20]);
    for (int i = 0; i < 4; i++) send(MODE_ALLOC, 4, 0);
    drain();
    release_all();

    // Random traffic over several heap limits; no idling in the last stretch
    for (int p = 0; p < 6; p++) begin
      set_limit(limits[p]);
      for (int i = 0; i < RAND_ITEMS / 6; i++) begin
        if (p == 5 && i > RAND_ITEMS / 6 - 120) calm = 1'b1;
        random_item();
        if (i % 90 == 89) release_all();
      end
    end
    drain();

    $display("covered %0d items: directed edge cases, full table, limits 0..131071,", sent);
    $display("random malloc/free/realloc with idle bursts on both channels");
    if (errors == 0) begin
      $display("best_fit_heap_allocator_tb: done, clean");
    end else begin
      $display("best_fit_heap_allocator_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("best_fit_heap_allocator_tb: done, errors");
    $finish;
  end

endmodule
